// File: sv/tscc_pkg.sv
// shared types and constants of the transport stream continuity checker
package tscc_pkg;

    localparam int PID_W       = 13;
    localparam int CC_W        = 4;
    localparam int ENT_W       = 6;
    localparam int TABLE_DEPTH = 1 << PID_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]       SYNC_VALUE = 8'h47;
    localparam logic [PID_W-1:0] NULL_PID   = 13'h1FFF;

    // table entry bit positions
    localparam int ENT_DUP_BIT  = 5;
    localparam int ENT_SEEN_BIT = 4;

    // classified header as it travels from front to back
    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic             sync_ok;
        logic             transport_error;
        logic             null_packet;
        logic             scrambled;
        logic             disc;
        logic             has_payload;
        logic             update;
        logic [CC_W-1:0]  cc;
    } t_item;

endpackage

// File: sv/tscc_front.sv
// front end: header field extraction, classification and input handshake
module tscc_front (
    input  logic                      i_valid,
    input  logic [7:0]                i_sync_byte,
    input  logic [7:0]                i_hdr_byte1,
    input  logic [7:0]                i_hdr_byte2,
    input  logic [7:0]                i_hdr_byte3,
    input  logic [7:0]                i_adapt_length,
    input  logic [7:0]                i_adapt_flags,
    input  logic                      i_queue_full,
    input  logic                      i_busy,
    output logic                      o_stall,
    output logic                      o_push,
    output tscc_pkg::t_item           o_item
);

    logic [tscc_pkg::PID_W-1:0] pid;
    logic [1:0]                 afc;
    logic                       sync_ok;
    logic                       te;
    logic                       is_null;
    logic                       checked;

    assign pid     = {i_hdr_byte1[4:0], i_hdr_byte2};
    assign afc     = i_hdr_byte3[5:4];
    assign sync_ok = (i_sync_byte == tscc_pkg::SYNC_VALUE);
    assign te      = sync_ok && i_hdr_byte1[7];
    assign is_null = sync_ok && !i_hdr_byte1[7] && (pid == tscc_pkg::NULL_PID);
    // packets that get the scrambling, discontinuity and counter checks
    assign checked = sync_ok && !i_hdr_byte1[7] && (pid != tscc_pkg::NULL_PID);

    assign o_stall = i_queue_full || i_busy;
    assign o_push  = i_valid && !o_stall;

    always_comb begin
        o_item                 = '0;
        o_item.pid             = pid;
        o_item.sync_ok         = sync_ok;
        o_item.transport_error = te;
        o_item.null_packet     = is_null;
        o_item.scrambled       = checked && (i_hdr_byte3[7:6] != 2'b00);
        o_item.disc            = checked && afc[1] && (i_adapt_length != 8'd0)
                                 && i_adapt_flags[7];
        o_item.has_payload     = afc[0];
        o_item.update          = checked && (afc != 2'b00);
        o_item.cc              = i_hdr_byte3[3:0];
    end

endmodule

// File: sv/tscc_queue.sv
// short fifo of classified headers between front and back
module tscc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tscc_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_not_empty,
    output tscc_pkg::t_item o_item
);

    tscc_pkg::t_item                r_mem [tscc_pkg::QUEUE_DEPTH];
    logic [tscc_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [tscc_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [tscc_pkg::QUEUE_AW:0]    r_count;
    logic [tscc_pkg::QUEUE_AW:0]    n_count;

    assign o_full      = (r_count == (tscc_pkg::QUEUE_AW+1)'(tscc_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: sv/tscc_back.sv
// back end: per-pid counter table, read-modify-write with forwarding, result register
module tscc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  tscc_pkg::t_item             i_item,
    output logic                        o_pop,
    output logic                        o_busy,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic                        o_sync_ok,
    output logic                        o_transport_error,
    output logic                        o_null_packet,
    output logic                        o_scrambled,
    output logic                        o_disc_indicator,
    output logic                        o_duplicate,
    output logic                        o_continuity_error,
    output logic [tscc_pkg::PID_W-1:0]  o_packet_pid
);

    logic [tscc_pkg::ENT_W-1:0] r_table [tscc_pkg::TABLE_DEPTH];

    logic                         r_clearing;
    logic [tscc_pkg::PID_W-1:0]   r_clr_addr;

    logic                         r_b_valid;
    tscc_pkg::t_item              r_b_item;
    logic [tscc_pkg::ENT_W-1:0]   r_rd_data;

    logic                         r_wr_valid;
    logic [tscc_pkg::PID_W-1:0]   r_wr_pid;
    logic [tscc_pkg::ENT_W-1:0]   r_wr_data;

    logic                         r_out_valid;
    logic                         r_out_dup;
    logic                         r_out_err;
    tscc_pkg::t_item              r_out_item;

    logic                         b_advance;
    logic [tscc_pkg::ENT_W-1:0]   ent;
    logic [tscc_pkg::CC_W-1:0]    last;
    logic [tscc_pkg::ENT_W-1:0]   fresh;
    logic                         upd_we;
    logic [tscc_pkg::ENT_W-1:0]   upd_data;
    logic                         dup_flag;
    logic                         err_flag;
    logic                         mem_we;
    logic [tscc_pkg::PID_W-1:0]   mem_addr;
    logic [tscc_pkg::ENT_W-1:0]   mem_data;

    assign b_advance = r_b_valid && (!r_out_valid || !i_stall);
    assign o_pop     = i_item_valid && (!r_b_valid || b_advance);
    assign o_busy    = r_clearing;

    // newest table value: the write of the previous transfer may not be in the read yet
    assign ent   = (r_wr_valid && (r_wr_pid == r_b_item.pid)) ? r_wr_data : r_rd_data;
    assign last  = ent[tscc_pkg::CC_W-1:0];
    assign fresh = {1'b0, 1'b1, r_b_item.cc};

    always_comb begin
        upd_we   = 1'b0;
        upd_data = fresh;
        dup_flag = 1'b0;
        err_flag = 1'b0;
        if (r_b_item.update) begin
            if (!ent[tscc_pkg::ENT_SEEN_BIT]) begin
                upd_we = 1'b1;
            end else if (r_b_item.has_payload && (r_b_item.cc == last + 1'b1)) begin
                upd_we = 1'b1;
            end else if (r_b_item.has_payload && (r_b_item.cc == last)
                         && !ent[tscc_pkg::ENT_DUP_BIT]) begin
                upd_we   = 1'b1;
                upd_data = ent | (tscc_pkg::ENT_W)'(1 << tscc_pkg::ENT_DUP_BIT);
                dup_flag = 1'b1;
            end else if (!r_b_item.has_payload && (r_b_item.cc == last)) begin
                upd_we = 1'b0;
            end else begin
                upd_we   = 1'b1;
                err_flag = !r_b_item.disc;
            end
        end
    end

    assign mem_we   = r_clearing || (b_advance && upd_we);
    assign mem_addr = r_clearing ? r_clr_addr : r_b_item.pid;
    assign mem_data = r_clearing ? '0 : upd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_addr] <= mem_data;
        end
        if (o_pop) begin
            r_rd_data <= r_table[i_item.pid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item <= i_item;
        end
        if (b_advance) begin
            r_out_item <= r_b_item;
            r_out_dup  <= dup_flag;
            r_out_err  <= err_flag;
        end
        if (b_advance && upd_we) begin
            r_wr_pid  <= r_b_item.pid;
            r_wr_data <= upd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
                r_wr_valid <= 1'b0;
            end else if (b_advance && upd_we) begin
                r_wr_valid <= 1'b1;
            end
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_advance) begin
                r_b_valid <= 1'b0;
            end
            if (b_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_sync_ok          = r_out_item.sync_ok;
    assign o_transport_error  = r_out_item.transport_error;
    assign o_null_packet      = r_out_item.null_packet;
    assign o_scrambled        = r_out_item.scrambled;
    assign o_disc_indicator   = r_out_item.disc;
    assign o_duplicate        = r_out_dup;
    assign o_continuity_error = r_out_err;
    assign o_packet_pid       = r_out_item.pid;

endmodule

// File: sv/ts_continuity_check.sv
// top level of the transport stream header and continuity counter checker
//
// input channel: i_valid / o_stall carry the first six bytes of one packet
// per transfer; a transfer happens at a clock edge with i_valid high and
// o_stall low
// output channel: o_valid / i_stall carry one result per packet, in order;
// the result holds while i_stall is high
// throughput: one packet per cycle when nothing stalls, set by the single
// read-modify-write of the per-pid table (one read port and one write port,
// with the last write forwarded to the next read)
// path to o_valid: an input transfer writes the queue, a pop loads the item
// and its table entry into the table stage, and the table stage loads the
// result register that drives o_valid
// reset: i_rst_n low on a clock edge clears all control state; afterwards the
// table is swept to zero, one pid a cycle, over all 8192 pids, and o_stall
// stays high until the sweep ends
// output stall: the result register holds, the table stage and the four
// entry queue fill, and o_stall rises once the queue is full
module ts_continuity_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_sync_byte,
    input  logic [7:0]                  i_hdr_byte1,
    input  logic [7:0]                  i_hdr_byte2,
    input  logic [7:0]                  i_hdr_byte3,
    input  logic [7:0]                  i_adapt_length,
    input  logic [7:0]                  i_adapt_flags,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_sync_ok,
    output logic                        o_transport_error,
    output logic                        o_null_packet,
    output logic                        o_scrambled,
    output logic                        o_disc_indicator,
    output logic                        o_duplicate,
    output logic                        o_continuity_error,
    output logic [tscc_pkg::PID_W-1:0]  o_packet_pid
);

    tscc_pkg::t_item front_item;
    tscc_pkg::t_item queue_item;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_not_empty;
    logic            busy;

    // header decode and input transfer control
    tscc_front u_front (
        .i_valid        (i_valid),
        .i_sync_byte    (i_sync_byte),
        .i_hdr_byte1    (i_hdr_byte1),
        .i_hdr_byte2    (i_hdr_byte2),
        .i_hdr_byte3    (i_hdr_byte3),
        .i_adapt_length (i_adapt_length),
        .i_adapt_flags  (i_adapt_flags),
        .i_queue_full   (queue_full),
        .i_busy         (busy),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_item         (front_item)
    );

    // decouples input transfers from output stalls
    tscc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .i_pop       (pop),
        .o_full      (queue_full),
        .o_not_empty (queue_not_empty),
        .o_item      (queue_item)
    );

    // per-pid table update and result register
    tscc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (queue_not_empty),
        .i_item             (queue_item),
        .o_pop              (pop),
        .o_busy             (busy),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_sync_ok          (o_sync_ok),
        .o_transport_error  (o_transport_error),
        .o_null_packet      (o_null_packet),
        .o_scrambled        (o_scrambled),
        .o_disc_indicator   (o_disc_indicator),
        .o_duplicate        (o_duplicate),
        .o_continuity_error (o_continuity_error),
        .o_packet_pid       (o_packet_pid)
    );

endmodule
